// ===== sv/pdu_pkg.sv =====
package pdu_pkg;

  localparam int GAIN_FRAC_BITS  = 8;
  localparam int SPEED_FRAC_BITS = 4;
  localparam int SCALE_BITS      = GAIN_FRAC_BITS + SPEED_FRAC_BITS;

  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 16;
  localparam int DUTY_W     = 8;
  localparam int MAG_W      = SPEED_W + 1;
  localparam int ERR_W      = 18;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int INTEG_W    = 32;
  localparam int KP_PROD_W  = GAIN_W + 1 + ERR_W;
  localparam int KD_PROD_W  = GAIN_W + 1 + DIFF_W;
  localparam int KI_PROD_W  = GAIN_W + 1 + INTEG_W;
  localparam int ACC_W      = KI_PROD_W + 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = DUTY_W'(255);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KP_GAIN  = 2'd0,
    REG_KD_GAIN  = 2'd1,
    REG_KI_GAIN  = 2'd2,
    REG_DUTY_MAX = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        [DUTY_W-1:0]  present_duty;
    logic signed [SPEED_W-1:0] target_speed;
    logic signed [SPEED_W-1:0] measured_speed;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] new_duty;
    logic              was_clamped;
  } out_t;

  // products of the three terms, plus the duty carried alongside
  typedef struct packed {
    logic signed [KP_PROD_W-1:0] kp_prod;
    logic signed [KD_PROD_W-1:0] kd_prod;
    logic signed [KI_PROD_W-1:0] ki_prod;
    logic        [DUTY_W-1:0]    duty;
  } prod_t;

endpackage

// ===== sv/pdu_duty_clamp.sv =====
module pdu_duty_clamp (
  input  pdu_pkg::prod_t               prod,
  input  logic [pdu_pkg::DUTY_W-1:0]   duty_max,
  output pdu_pkg::out_t                res
);
  import pdu_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS =
    ACC_W'((64'd1 << SCALE_BITS) - 64'd1);

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_bias;
  logic signed [ACC_W-1:0] quot;
  logic signed [ACC_W-1:0] total;
  logic signed [ACC_W-1:0] limit;

  always_comb begin
    acc      = ACC_W'(prod.kp_prod) + ACC_W'(prod.kd_prod) + ACC_W'(prod.ki_prod);
    // bias negatives so the arithmetic shift truncates toward zero
    acc_bias = acc + (acc[ACC_W-1] ? ROUND_BIAS : '0);
    quot     = acc_bias >>> SCALE_BITS;
    total    = quot + $signed({{(ACC_W-DUTY_W){1'b0}}, prod.duty});
    limit    = $signed({{(ACC_W-DUTY_W){1'b0}}, duty_max});
    if (total[ACC_W-1]) begin
      res.new_duty    = '0;
      res.was_clamped = 1'b1;
    end else if (total > limit) begin
      res.new_duty    = duty_max;
      res.was_clamped = 1'b1;
    end else begin
      res.new_duty    = total[DUTY_W-1:0];
      res.was_clamped = 1'b0;
    end
  end

endmodule

// ===== sv/pid_duty_update_unit.sv =====
// Channel   | Signals                         | Payload
// ----------+---------------------------------+------------------------------------------
// in        | in_valid / in_ready / in_data   | present_duty, target_speed, measured_speed
// out       | out_valid / out_ready / out_data| new_duty, was_clamped
// cfg       | cfg_wr_en / cfg_addr / cfg_wdata| kp, kd, ki gains, duty_max (write only)
//
// Path: an accepted request loads the input reg, then the product reg, then
// the result reg, from which it can be taken.
// Throughput: one request per cycle while out_ready does not stall; the product stage with
// its three gain multipliers and the error/integral state update sets the pace.
// Reset (synchronous, rst high) empties the pipe, zeroes the gains, previous
// error and integral, and sets duty_max to 255.
// Stalls: each stage holds while the next one is full and not moving, so
// empty stages keep filling while a result waits on out_ready.
module pid_duty_update_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pdu_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pdu_pkg::out_t                     out_data,
  input  logic                              cfg_wr_en,
  input  logic [pdu_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pdu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pdu_pkg::*;

  // config registers
  logic [GAIN_W-1:0] kp_gain;
  logic [GAIN_W-1:0] kd_gain;
  logic [GAIN_W-1:0] ki_gain;
  logic [DUTY_W-1:0] duty_max;

  // controller state
  logic signed [ERR_W-1:0]   prev_err;
  logic signed [INTEG_W-1:0] integral;

  // pipeline registers
  logic  req_valid;
  in_t   req;
  logic  prod_valid;
  prod_t prod;

  // stage handshakes
  logic out_free;
  logic prod_fire;   // product stage -> result register
  logic req_fire;    // input register -> product stage (state updates here)

  // stage A combinational
  logic        [MAG_W-1:0]   t_ext, m_ext, t_mag, m_mag;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_next;
  prod_t                     prod_next;
  out_t                      res;

  assign out_free  = !out_valid || out_ready;
  assign prod_fire = prod_valid && out_free;
  assign req_fire  = req_valid && (!prod_valid || prod_fire);
  assign in_ready  = !req_valid || req_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain  <= '0;
      kd_gain  <= '0;
      ki_gain  <= '0;
      duty_max <= DUTY_MAX_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_KP_GAIN:  kp_gain  <= cfg_wdata;
        REG_KD_GAIN:  kd_gain  <= cfg_wdata;
        REG_KI_GAIN:  ki_gain  <= cfg_wdata;
        REG_DUTY_MAX: duty_max <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // error = |target| - |measured|; the most negative speed maps to +32768
  always_comb begin
    t_ext = {req.target_speed[SPEED_W-1], req.target_speed};
    m_ext = {req.measured_speed[SPEED_W-1], req.measured_speed};
    t_mag = t_ext[MAG_W-1] ? MAG_W'(-t_ext) : t_ext;
    m_mag = m_ext[MAG_W-1] ? MAG_W'(-m_ext) : m_ext;
    err   = $signed(ERR_W'(t_mag)) - $signed(ERR_W'(m_mag));
    diff  = DIFF_W'(err) - DIFF_W'(prev_err);

    // saturating integral update
    integ_sum = (INTEG_W+1)'(integral) + (INTEG_W+1)'(err);
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                      : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_next = integ_sum[INTEG_W-1:0];
    end

    prod_next.kp_prod = $signed({1'b0, kp_gain}) * err;
    prod_next.kd_prod = $signed({1'b0, kd_gain}) * diff;
    prod_next.ki_prod = $signed({1'b0, ki_gain}) * integral;   // integral before this error
    prod_next.duty    = req.present_duty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
      prev_err   <= '0;
      integral   <= '0;
    end else begin
      if (in_ready) begin
        req_valid <= in_valid;
      end
      if (req_fire || prod_fire) begin
        prod_valid <= req_fire;
      end
      if (out_free) begin
        out_valid <= prod_valid;
      end
      if (req_fire) begin
        prev_err <= err;
        integral <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (req_fire) begin
      prod <= prod_next;
    end
    if (prod_fire) begin
      out_data <= res;
    end
  end

  pdu_duty_clamp u_clamp (
    .prod     (prod),
    .duty_max (duty_max),
    .res      (res)
  );

  // an empty input stage always takes a request
  a_in_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !req_valid |-> in_ready)
    else $error("input stage empty but not ready");

  // previous error follows each request exactly once
  a_prev_err: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> prev_err == $past(err))
    else $error("previous error not updated");

  // state is frozen while no request moves through the product stage
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !req_fire |=> $stable(prev_err) && $stable(integral))
    else $error("controller state changed without a request");

  // a nonnegative error never wraps a nonnegative integral negative
  a_integ_sat: assert property (@(posedge clk) disable iff (rst)
    req_fire && !err[ERR_W-1] && !integral[INTEG_W-1] |=> !integral[INTEG_W-1])
    else $error("integral wrapped instead of saturating");

  // combinational clamp never exceeds the live limit
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    prod_valid |-> res.new_duty <= duty_max)
    else $error("duty above clamp limit");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import pdu_pkg::*;

  // Timing and run shape
  localparam int RESET_CYCLES = 12;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_REQS   = 95;
  localparam int LONG_STALL   = 300;   // receiver hold-off, in cycles
  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int SETTLE       = 10;    // idle wait after the last result is checked
  localparam int MAX_PRINTED  = 100;   // keep a broken run's log readable
  localparam int ZERO_BAND    = 2048;  // integral window walked in small steps

  localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_MIN = -(longint'(1) <<< (INTEG_W - 1));
  localparam longint GAIN_UNIT = longint'(1) <<< SCALE_BITS;

  // Duty predictor plus the queue of duties still owed by the pipe.
  class duty_checker;
    logic        [GAIN_W-1:0]  kp, kd, ki;
    logic        [DUTY_W-1:0]  duty_cap;
    logic signed [ERR_W-1:0]   last_err;
    logic signed [INTEG_W-1:0] err_sum;
    out_t                      expected_duty_q[$];
    int                        errors;
    int                        results_seen;

    function new();
      kp = '0;
      kd = '0;
      ki = '0;
      duty_cap = DUTY_MAX_RESET;
      last_err = '0;
      err_sum = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_KP_GAIN:  kp = val;
        REG_KD_GAIN:  kd = val;
        REG_KI_GAIN:  ki = val;
        REG_DUTY_MAX: duty_cap = val[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_duty_q.size();
    endfunction

    // Request accepted: work out its duty, then advance error history.
    function void note_request(in_t req);
      int     tgt_mag, meas_mag, err;
      longint slope, acc, corr, sum;
      out_t   want;
      tgt_mag = $signed(req.target_speed);
      meas_mag = $signed(req.measured_speed);
      if (tgt_mag < 0) tgt_mag = -tgt_mag;
      if (meas_mag < 0) meas_mag = -meas_mag;
      err = tgt_mag - meas_mag;
      slope = longint'(err) - longint'(last_err);
      acc = longint'(kp) * err + longint'(kd) * slope + longint'(ki) * longint'(err_sum);
      corr = acc / GAIN_UNIT;  // SV division truncates toward zero
      sum = longint'(req.present_duty) + corr;
      want.was_clamped = 1'b0;
      if (sum < 0) begin
        sum = 0;
        want.was_clamped = 1'b1;
      end else if (sum > longint'(duty_cap)) begin
        sum = longint'(duty_cap);
        want.was_clamped = 1'b1;
      end
      want.new_duty = DUTY_W'(sum);
      expected_duty_q.push_back(want);
      last_err = ERR_W'(err);
      sum = longint'(err_sum) + err;
      if (sum > INTEG_MAX) sum = INTEG_MAX;
      else if (sum < INTEG_MIN) sum = INTEG_MIN;
      err_sum = INTEG_W'(sum);
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      results_seen++;
      if (expected_duty_q.size() == 0) begin
        report($sformatf("result %0d with nothing pending (duty %0d clamp %0b)",
                         results_seen, got.new_duty, got.was_clamped));
        return;
      end
      want = expected_duty_q.pop_front();
      if (got.new_duty !== want.new_duty)
        report($sformatf("result %0d new_duty got %0d want %0d",
                         results_seen, got.new_duty, want.new_duty));
      if (got.was_clamped !== want.was_clamped)
        report($sformatf("result %0d was_clamped got %b want %b",
                         results_seen, got.was_clamped, want.was_clamped));
    endtask
  endclass

  // DUT signals, every input known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_wr_en = 1'b0;
  cfg_reg_t              cfg_addr = REG_KP_GAIN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  duty_checker sb = new();

  // Idle odds per side in percent, and the one-shot long hold-off request
  int   send_idle_pct = 17;
  int   recv_idle_pct = 82;
  logic long_stall_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pid_duty_update_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------
  function automatic in_t make_req(int duty, int tgt, int meas);
    in_t r;
    r.present_duty = DUTY_W'(duty);
    r.target_speed = SPEED_W'(tgt);
    r.measured_speed = SPEED_W'(meas);
    return r;
  endfunction

  function automatic logic signed [SPEED_W-1:0] extreme_speed();
    case ($urandom_range(5))
      0: return 16'sh8000;  // most negative: magnitude 32768
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      4: return 16'sh0001;
      default: return SPEED_W'($urandom);
    endcase
  endfunction

  // Magnitude with a random sign; 32768 only exists as the negative code.
  function automatic logic signed [SPEED_W-1:0] with_sign(int m);
    if (m == 32768 || $urandom_range(1) == 1) return SPEED_W'(-m);
    return SPEED_W'(m);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom_range(15));
      3: return GAIN_W'($urandom_range(511));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [DUTY_W-1:0] pick_duty_max();
    case ($urandom_range(3))
      0: return 8'd255;
      1: return 8'd247;
      2: return 8'd0;
      default: return DUTY_W'($urandom);
    endcase
  endfunction

  // Mostly near-regulation traffic (small error, either speed sign),
  // plus fully random and edge-value speeds.
  function automatic in_t random_request();
    in_t                       r;
    int                        pick;
    logic signed [SPEED_W-1:0] t;
    pick = $urandom_range(99);
    r.present_duty = DUTY_W'($urandom);
    if ($urandom_range(9) == 0) r.present_duty = ($urandom_range(1) == 1) ? 8'hff : 8'h00;
    else if ($urandom_range(9) == 0) r.present_duty = sb.duty_cap + DUTY_W'($urandom_range(1));
    if (pick < 55) begin
      t = SPEED_W'($urandom);
      r.target_speed = t;
      r.measured_speed = (($urandom_range(1) == 1) ? t : -t)
                         + SPEED_W'($urandom_range(64)) - SPEED_W'(32);
    end else if (pick < 80) begin
      r.target_speed = SPEED_W'($urandom);
      r.measured_speed = SPEED_W'($urandom);
    end else begin
      r.target_speed = extreme_speed();
      r.measured_speed = extreme_speed();
    end
    return r;
  endfunction

  // Pushes the integral toward one rail: near-full-scale error of sign dir,
  // small steps while close to zero so the zero crossing is seen in detail.
  function automatic in_t integral_step(int dir);
    in_t r;
    int  big, little;
    if (sb.err_sum > -ZERO_BAND && sb.err_sum < ZERO_BAND) begin
      big = $urandom_range(200);
      little = 0;
    end else begin
      big = 32768 - $urandom_range(255);
      little = $urandom_range(255);
    end
    r.present_duty = DUTY_W'($urandom);
    r.target_speed = with_sign((dir > 0) ? big : little);
    r.measured_speed = with_sign((dir > 0) ? little : big);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers: all inputs change on the falling edge
  // ---------------------------------------------------------------------

  // Offer one request; valid stays up after acceptance so back-to-back
  // requests never drop it. Returns on the falling edge after acceptance.
  task send_request(in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    @(negedge clk);
  endtask

  // Stop offering and let the pipe empty before touching registers.
  task wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task configure(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] kd, logic [GAIN_W-1:0] ki,
                 logic [DUTY_W-1:0] dmax);
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KD_GAIN, kd);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_DUTY_MAX, CFG_DATA_W'(dmax));
  endtask

  // Receiver: random ready, or one long hold-off counted here so the pipe
  // fills and in_ready drops while the sender keeps pushing.
  initial begin : sink
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Results are sampled on the rising edge, before the DUT updates
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: a hang or a lost result shows up as a long quiet stretch
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset values: zero gains, cap 255, so duty passes straight through
    send_request(make_req(0, 0, 0));
    send_request(make_req(255, 32767, -32768));
    send_request(make_req(128, -32768, -1));

    // Full-scale gains with full-scale error of both signs
    wait_idle();
    configure('1, '1, '1, 8'd255);
    send_request(make_req(0, -32768, 0));
    send_request(make_req(255, 0, -32768));
    send_request(make_req(0, -32768, -32768));
    send_request(make_req(255, 32767, 32767));
    send_request(make_req(128, 1, 0));

    // Truncation toward zero of small corrections, and duty above the cap
    wait_idle();
    configure(16'd4097, '0, '0, 8'd247);
    send_request(make_req(100, 0, 1));
    send_request(make_req(100, 1, 0));
    send_request(make_req(255, 0, 0));
    send_request(make_req(248, 0, 0));
    send_request(make_req(247, 0, 0));
    wait_idle();
    configure(16'd4095, '0, '0, 8'd247);
    send_request(make_req(100, 0, 1));
    send_request(make_req(0, 0, 16));

    // Cap of zero: every duty must come out 0
    wait_idle();
    configure(16'd256, 16'd256, 16'd256, 8'd0);
    send_request(make_req(0, 0, 0));
    send_request(make_req(255, 32767, 0));
    send_request(make_req(0, -32768, 32767));

    // Random phases: sender-light idling, then receiver-light, then none
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      send_idle_pct = (p < 3) ? 17 : (p < 6) ? 82 : 0;
      recv_idle_pct = (p < 3) ? 82 : (p < 6) ? 17 : 0;
      if (p == 0) configure('1, '1, '1, 8'd247);
      else configure(pick_gain(), pick_gain(), pick_gain(), pick_duty_max());
      for (int i = 0; i < PHASE_REQS; i++) begin
        if (p == 6 && i == 10) long_stall_req = 1'b1;
        send_request(random_request());
      end
    end

    // Integral across zero: walk it below the band around zero, then back up
    // past it, in small steps inside the band. ki of 1.0 makes the integral
    // visible in the duty near zero.
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure('0, '0, 16'd256, 8'd255);
    while (sb.err_sum > -ZERO_BAND) send_request(integral_step(-1));
    while (sb.err_sum < 2 * ZERO_BAND) send_request(integral_step(1));

    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pdu_pkg.sv
sv/pdu_duty_clamp.sv
sv/pid_duty_update_unit.sv
dv/tb_top.sv
